>>> hdl/rbh_pkg.sv
// ----------------------------------------------------------------------------
// rbh_pkg
// Shared types, register map and bound helpers for the ray/box hit tester.
// ----------------------------------------------------------------------------
package rbh_pkg;

  localparam int NUM_AXES  = 3;
  localparam int NUM_FACES = 6;
  localparam int QUO_BITS  = 31;   // k saturates at 2^31 - 1

  // register word index (byte address / 4)
  typedef enum logic [2:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } reg_idx_t;

  typedef enum logic {
    OP_RAY   = 1'b0,
    OP_POINT = 1'b1
  } op_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][31:0] lo;
    logic [NUM_AXES-1:0][31:0] hi;
  } box_t;

  // per-query context carried down the pipeline
  typedef struct packed {
    op_t                       op;
    logic [NUM_AXES-1:0][31:0] o;
    logic [NUM_AXES-1:0][32:0] s;
    logic [30:0]               tol;
  } ctx_t;

  // lower bound widened by the tolerance, exact
  function automatic logic signed [33:0] lo_bound(input logic [31:0] v,
                                                  input logic [30:0] tol);
    lo_bound = $signed({{2{v[31]}}, v}) - $signed({3'b000, tol});
  endfunction

  // upper bound widened by the tolerance, exact
  function automatic logic signed [33:0] hi_bound(input logic [31:0] v,
                                                  input logic [30:0] tol);
    hi_bound = $signed({{2{v[31]}}, v}) + $signed({3'b000, tol});
  endfunction

endpackage

>>> hdl/rbh_divider.sv
// ----------------------------------------------------------------------------
// rbh_divider
// Six-lane pipelined restoring divider: k = num * 2^FRAC_BITS / den,
// one quotient bit per stage after a saturation check stage.
// ----------------------------------------------------------------------------
module rbh_divider #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  rbh_pkg::ctx_t                          in_ctx,
  input  logic [rbh_pkg::NUM_FACES-1:0]          in_ok,
  input  logic [rbh_pkg::NUM_FACES-1:0][31:0]    in_num,
  input  logic [rbh_pkg::NUM_FACES-1:0][31:0]    in_den,
  output logic                                   out_valid,
  output rbh_pkg::ctx_t                          out_ctx,
  output logic [rbh_pkg::NUM_FACES-1:0]          out_ok,
  output logic [rbh_pkg::NUM_FACES-1:0][rbh_pkg::QUO_BITS-1:0] out_q
);
  import rbh_pkg::*;

  localparam int NST = QUO_BITS + 1;

  logic [NST-1:0]          vld;
  ctx_t                    ctx [NST];
  logic [NUM_FACES-1:0]    ok  [NST];
  logic [NUM_FACES-1:0]    sat [NST];
  logic [63:0]             rem [NST][NUM_FACES];
  logic [31:0]             den [NST][NUM_FACES];
  logic [QUO_BITS-1:0]     quo [NST][NUM_FACES];

  // stage 0: saturation check, load remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx[0] <= in_ctx;
      ok[0]  <= in_ok;
      for (int f = 0; f < NUM_FACES; f++) begin
        rem[0][f] <= 64'(in_num[f]) << FRAC_BITS;
        den[0][f] <= in_den[f];
        quo[0][f] <= '0;
        sat[0][f] <= (64'(in_num[f]) << FRAC_BITS) >= (64'(in_den[f]) << QUO_BITS);
      end
    end
  end

  genvar j, f;
  generate
    for (j = 1; j < NST; j++) begin : g_stage
      localparam int SH = QUO_BITS - j;
      logic [NUM_FACES-1:0][64:0] trial;

      for (f = 0; f < NUM_FACES; f++) begin : g_lane
        assign trial[f] = {1'b0, rem[j-1][f]} - {1'b0, 64'(den[j-1][f]) << SH};
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[j] <= 1'b0;
        end else if (en) begin
          vld[j] <= vld[j-1];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          ctx[j] <= ctx[j-1];
          ok[j]  <= ok[j-1];
          sat[j] <= sat[j-1];
          for (int l = 0; l < NUM_FACES; l++) begin
            den[j][l] <= den[j-1][l];
            if (!trial[l][64]) begin
              rem[j][l] <= trial[l][63:0];
            end else begin
              rem[j][l] <= rem[j-1][l];
            end
            quo[j][l] <= {quo[j-1][l][QUO_BITS-2:0], ~trial[l][64]};
          end
        end
      end
    end
  endgenerate

  assign out_valid = vld[NST-1];
  assign out_ctx   = ctx[NST-1];
  assign out_ok    = ok[NST-1];

  always_comb begin
    for (int l = 0; l < NUM_FACES; l++) begin
      out_q[l] = sat[NST-1][l] ? {QUO_BITS{1'b1}} : quo[NST-1][l];
    end
  end

endmodule

>>> hdl/rbh_face_check.sv
// ----------------------------------------------------------------------------
// rbh_face_check
// Hit point on the two other axes of each face and widened bounds test.
// Stage 1 multiplies k by the slope, stage 2 adds the origin and compares.
// ----------------------------------------------------------------------------
module rbh_face_check #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  rbh_pkg::box_t                          box,
  input  logic                                   in_valid,
  input  rbh_pkg::ctx_t                          in_ctx,
  input  logic [rbh_pkg::NUM_FACES-1:0]          in_ok,
  input  logic [rbh_pkg::NUM_FACES-1:0][rbh_pkg::QUO_BITS-1:0] in_q,
  output logic                                   out_valid,
  output rbh_pkg::ctx_t                          out_ctx,
  output logic [rbh_pkg::NUM_FACES-1:0]          out_hit
);
  import rbh_pkg::*;

  logic                 vld_m;
  ctx_t                 ctx_m;
  logic [NUM_FACES-1:0] ok_m;
  logic [NUM_FACES-1:0][1:0][64:0] prod;
  logic [NUM_FACES-1:0][1:0]       inb;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_m     <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld_m     <= in_valid;
      out_valid <= vld_m;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_m   <= in_ctx;
      ok_m    <= in_ok;
      out_ctx <= ctx_m;
    end
  end

  genvar f, k;
  generate
    for (f = 0; f < NUM_FACES; f++) begin : g_face
      localparam int A = f / 2;
      for (k = 0; k < 2; k++) begin : g_axis
        localparam int B = (A + 1 + k) % NUM_AXES;
        logic signed [64:0] shifted;
        logic signed [65:0] p;
        logic signed [33:0] lo_w;
        logic signed [33:0] hi_w;

        always_ff @(posedge clk) begin
          if (en) begin
            prod[f][k] <= $signed({1'b0, in_q[f]}) * $signed(in_ctx.s[B]);
          end
        end

        assign shifted = $signed(prod[f][k]) >>> FRAC_BITS;
        assign p       = $signed({{34{ctx_m.o[B][31]}}, ctx_m.o[B]})
                       + $signed({shifted[64], shifted});
        assign lo_w    = lo_bound(box.lo[B], ctx_m.tol);
        assign hi_w    = hi_bound(box.hi[B], ctx_m.tol);
        assign inb[f][k] = (p >= $signed({{32{lo_w[33]}}, lo_w}))
                        && (p <= $signed({{32{hi_w[33]}}, hi_w}));
      end

      always_ff @(posedge clk) begin
        if (en) begin
          out_hit[f] <= ok_m[f] && inb[f][0] && inb[f][1];
        end
      end
    end
  endgenerate

endmodule

>>> hdl/ray_box_hit_test_unit.sv
// ----------------------------------------------------------------------------
// ray_box_hit_test_unit
// Ray or point test against a register-held axis-aligned box.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while the output word is taken; the
//   depth is set by the six-lane restoring divider, one quotient bit per stage.
// The whole pipeline holds when the output word is not taken.
// Reset (rst, synchronous) clears all valid bits and the box registers.
module ray_box_hit_test_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  // APB configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // [31:0] origin_x, [63:32] origin_y, [95:64] origin_z, [127:96] toward_x,
  // [159:128] toward_y, [191:160] toward_z, [222:192] tolerance, [223] zero
  input  logic [223:0] s_tdata,
  // [0] operation
  input  logic [0:0]   s_tuser,
  // output stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // [0] hit, [7:1] zero
  output logic [7:0]   m_tdata
);
  import rbh_pkg::*;

  box_t     box;
  reg_idx_t widx;
  logic     en;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      box <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        REG_MIN_X: box.lo[0] <= pwdata;
        REG_MIN_Y: box.lo[1] <= pwdata;
        REG_MIN_Z: box.lo[2] <= pwdata;
        REG_MAX_X: box.hi[0] <= pwdata;
        REG_MAX_Y: box.hi[1] <= pwdata;
        REG_MAX_Z: box.hi[2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_MIN_X: prdata = box.lo[0];
      REG_MIN_Y: prdata = box.lo[1];
      REG_MIN_Z: prdata = box.lo[2];
      REG_MAX_X: prdata = box.hi[0];
      REG_MAX_Y: prdata = box.hi[1];
      REG_MAX_Z: prdata = box.hi[2];
      default:   prdata = '0;
    endcase
  end

  // advance everything unless the output word is stuck
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // stage 0: input register
  logic                      v0;
  op_t                       op0;
  logic [NUM_AXES-1:0][31:0] o0;
  logic [NUM_AXES-1:0][31:0] t0;
  logic [30:0]               tol0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op0  <= op_t'(s_tuser[0]);
      tol0 <= s_tdata[222:192];
      for (int a = 0; a < NUM_AXES; a++) begin
        o0[a] <= s_tdata[32*a +: 32];
        t0[a] <= s_tdata[96 + 32*a +: 32];
      end
    end
  end

  // stage 1: slopes, face numerators, skip flags, magnitudes
  logic [NUM_AXES-1:0][32:0]  slope;
  logic [NUM_FACES-1:0][32:0] num;
  logic [NUM_FACES-1:0]       ok_c;
  logic [NUM_FACES-1:0][31:0] nmag_c;
  logic [NUM_FACES-1:0][31:0] dmag_c;
  ctx_t                       ctx_c;

  always_comb begin
    logic [31:0] plane;
    logic [32:0] tmp;
    for (int a = 0; a < NUM_AXES; a++) begin
      slope[a] = {t0[a][31], t0[a]} - {o0[a][31], o0[a]};
    end
    for (int f = 0; f < NUM_FACES; f++) begin
      plane  = f[0] ? box.hi[f/2] : box.lo[f/2];
      num[f] = {plane[31], plane} - {o0[f/2][31], o0[f/2]};
      // skip a flat axis and a face behind the origin
      ok_c[f] = (slope[f/2] != '0)
             && ((num[f] == '0) || (num[f][32] == slope[f/2][32]));
      tmp       = num[f][32] ? -num[f] : num[f];
      nmag_c[f] = tmp[31:0];
      tmp       = slope[f/2][32] ? -slope[f/2] : slope[f/2];
      dmag_c[f] = tmp[31:0];
    end
    ctx_c.op  = op0;
    ctx_c.o   = o0;
    ctx_c.s   = slope;
    ctx_c.tol = tol0;
  end

  logic                       v1;
  ctx_t                       ctx1;
  logic [NUM_FACES-1:0]       ok1;
  logic [NUM_FACES-1:0][31:0] nmag1;
  logic [NUM_FACES-1:0][31:0] dmag1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx1  <= ctx_c;
      ok1   <= ok_c;
      nmag1 <= nmag_c;
      dmag1 <= dmag_c;
    end
  end

  logic                                      dv_valid;
  ctx_t                                      dv_ctx;
  logic [NUM_FACES-1:0]                      dv_ok;
  logic [NUM_FACES-1:0][QUO_BITS-1:0]        dv_q;

  rbh_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v1),
    .in_ctx    (ctx1),
    .in_ok     (ok1),
    .in_num    (nmag1),
    .in_den    (dmag1),
    .out_valid (dv_valid),
    .out_ctx   (dv_ctx),
    .out_ok    (dv_ok),
    .out_q     (dv_q)
  );

  logic                 fc_valid;
  ctx_t                 fc_ctx;
  logic [NUM_FACES-1:0] fc_hit;

  rbh_face_check #(.FRAC_BITS(FRAC_BITS)) u_face (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .box       (box),
    .in_valid  (dv_valid),
    .in_ctx    (dv_ctx),
    .in_ok     (dv_ok),
    .in_q      (dv_q),
    .out_valid (fc_valid),
    .out_ctx   (fc_ctx),
    .out_hit   (fc_hit)
  );

  // point containment on the carried origin
  logic [NUM_AXES-1:0] pt_in;
  logic                hit_next;
  logic                hit;

  always_comb begin
    logic signed [33:0] ov;
    for (int a = 0; a < NUM_AXES; a++) begin
      ov = $signed({{2{fc_ctx.o[a][31]}}, fc_ctx.o[a]});
      pt_in[a] = (ov >= lo_bound(box.lo[a], fc_ctx.tol))
              && (ov <= hi_bound(box.hi[a], fc_ctx.tol));
    end
    hit_next = (fc_ctx.op == OP_POINT) ? (&pt_in) : (|fc_hit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= fc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit <= hit_next;
    end
  end

  assign m_tdata = {7'b0, hit};

endmodule

>>> hdl/rbh_checker.sv
// ----------------------------------------------------------------------------
// rbh_checker
// Port-level checks for the ray/box hit tester, bound to the top level.
// ----------------------------------------------------------------------------
module rbh_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("output word changed while stalled");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:1] == 7'd0))
    else $error("output padding not zero");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input held off with empty output");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind ray_box_hit_test_unit rbh_checker u_rbh_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
